// ===== hw/rtl/morse_code_keyer_assert.svh =====
// morse_code_keyer_assert.svh: assertion macros for the keyer rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef MORSE_CODE_KEYER_ASSERT_SVH
`define MORSE_CODE_KEYER_ASSERT_SVH
`ifndef SYNTHESIS
// expr must never hold while out of reset
`define MCK_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: never");
// ante implies cons in the same cycle
`define MCK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// ante implies cons in the next cycle
`define MCK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define MCK_ASSERT_NEVER(label, clk, rst_n, expr)
`define MCK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MCK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/mck_pkg.sv =====
// mck_pkg: payload types, character constants and the morse code rom
// no dependencies
package mck_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       last_of_message;
	} char_t;

	typedef struct packed {
		logic       led_on;
		logic [2:0] units;
		logic       bad_char;
		logic       last;
	} seg_t;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_Z     = 8'h5A;

	localparam logic [2:0] UNITS_DOT      = 3'd1;
	localparam logic [2:0] UNITS_DASH     = 3'd3;
	localparam logic [2:0] UNITS_SYM_GAP  = 3'd1;
	localparam logic [2:0] UNITS_CHAR_GAP = 3'd3;
	localparam logic [2:0] UNITS_WORD_GAP = 3'd7;
	localparam logic [2:0] UNITS_ERROR    = 3'd0;

	// bits 7..3: code, first symbol in bit 3, 1 = dash; bits 2..0: symbol count
	function automatic logic [7:0] morse_entry(input logic [5:0] idx);
		logic [7:0] e;
		unique case (idx)
			6'd0:  e = {5'h1F, 3'd5};
			6'd1:  e = {5'h1E, 3'd5};
			6'd2:  e = {5'h1C, 3'd5};
			6'd3:  e = {5'h18, 3'd5};
			6'd4:  e = {5'h10, 3'd5};
			6'd5:  e = {5'h00, 3'd5};
			6'd6:  e = {5'h01, 3'd5};
			6'd7:  e = {5'h03, 3'd5};
			6'd8:  e = {5'h07, 3'd5};
			6'd9:  e = {5'h0F, 3'd5};
			6'd10: e = {5'h02, 3'd2};
			6'd11: e = {5'h01, 3'd4};
			6'd12: e = {5'h05, 3'd4};
			6'd13: e = {5'h01, 3'd3};
			6'd14: e = {5'h00, 3'd1};
			6'd15: e = {5'h04, 3'd4};
			6'd16: e = {5'h03, 3'd3};
			6'd17: e = {5'h00, 3'd4};
			6'd18: e = {5'h00, 3'd2};
			6'd19: e = {5'h0E, 3'd4};
			6'd20: e = {5'h05, 3'd3};
			6'd21: e = {5'h02, 3'd4};
			6'd22: e = {5'h03, 3'd2};
			6'd23: e = {5'h01, 3'd2};
			6'd24: e = {5'h07, 3'd3};
			6'd25: e = {5'h06, 3'd4};
			6'd26: e = {5'h0B, 3'd4};
			6'd27: e = {5'h02, 3'd3};
			6'd28: e = {5'h00, 3'd3};
			6'd29: e = {5'h01, 3'd1};
			6'd30: e = {5'h04, 3'd3};
			6'd31: e = {5'h08, 3'd4};
			6'd32: e = {5'h06, 3'd3};
			6'd33: e = {5'h09, 3'd4};
			6'd34: e = {5'h0D, 3'd4};
			6'd35: e = {5'h03, 3'd4};
			default: e = 8'h00;
		endcase
		return e;
	endfunction

endpackage

// ===== hw/rtl/morse_code_keyer.sv =====
// morse_code_keyer: turns text characters into morse keying segments
// depends on mck_pkg and morse_code_keyer_assert.svh
//
// usage:
//   char channel (char_valid / char_stall / char_data) takes one character
//   per transfer. seg channel (seg_valid / seg_stall / seg_data) gives the
//   keying segments: led level, length in units, error flag, and last on
//   the final segment of each character.
//   once a character is accepted, the shared sequencer puts out one
//   segment per cycle while the output register is free: a letter or digit of
//   n symbols gives 2n-1 segments, plus a 3-unit gap when it is not the
//   first of a message, so up to ten segments. a space or a bad character
//   gives one segment, a nul gives none and only ends the message.
//   char_stall is high while the sequencer is busy with a character; the
//   next character is taken once the last segment sits in the output
//   register, even if the receiver has not yet taken it.
//   on a stall of a valid segment the register holds and the sequencer
//   waits. reset clears the message state and empties the output register.
module morse_code_keyer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_stall,
	input  mck_pkg::char_t char_data,
	output logic          seg_valid,
	input  logic          seg_stall,
	output mck_pkg::seg_t seg_data
);
	import mck_pkg::*;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_SPACE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	logic       busy_q;
	logic [1:0] kind_q;
	logic       gap_q;
	logic       sym_gap_q;
	logic [4:0] code_q;
	logic [2:0] cnt_q;
	logic       started_q;
	logic       out_valid_q;
	seg_t       out_q;

	logic       accept;
	logic       is_digit;
	logic       is_alpha;
	logic [7:0] idx_full;
	logic [7:0] entry;
	logic       slot_free;
	logic       step;
	seg_t       seg_next;
	logic       done_next;

	assign accept    = char_valid && !char_stall;
	assign char_stall = busy_q;
	assign is_digit  = (char_data.character >= CHAR_ZERO) && (char_data.character <= CHAR_NINE);
	assign is_alpha  = (char_data.character >= CHAR_A) && (char_data.character <= CHAR_Z);
	assign idx_full  = is_digit ? (char_data.character - CHAR_ZERO)
	                            : (char_data.character - CHAR_A + 8'd10);
	assign entry     = morse_entry(idx_full[5:0]);
	assign slot_free = !out_valid_q || !seg_stall;
	assign step      = busy_q && slot_free;

	// segment selection for the current sequencer step
	always_comb begin
		seg_next  = '0;
		done_next = 1'b0;
		unique case (kind_q)
			KIND_SPACE: begin
				seg_next.units = UNITS_WORD_GAP;
				seg_next.last  = 1'b1;
				done_next      = 1'b1;
			end
			KIND_ERROR: begin
				seg_next.units    = UNITS_ERROR;
				seg_next.bad_char = 1'b1;
				seg_next.last     = 1'b1;
				done_next         = 1'b1;
			end
			default: begin
				priority if (gap_q) begin
					seg_next.units = UNITS_CHAR_GAP;
				end else if (sym_gap_q) begin
					seg_next.units = UNITS_SYM_GAP;
				end else begin
					seg_next.led_on = 1'b1;
					seg_next.units  = code_q[0] ? UNITS_DASH : UNITS_DOT;
					seg_next.last   = (cnt_q == 3'd1);
					done_next       = (cnt_q == 3'd1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			kind_q      <= KIND_CHAR;
			gap_q       <= 1'b0;
			sym_gap_q   <= 1'b0;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				gap_q     <= started_q;
				sym_gap_q <= 1'b0;
				cnt_q     <= entry[2:0];
				priority if (char_data.character == CHAR_NUL) begin
					started_q <= 1'b0;
				end else if (char_data.character == CHAR_SPACE && started_q) begin
					busy_q    <= 1'b1;
					kind_q    <= KIND_SPACE;
					started_q <= !char_data.last_of_message;
				end else if (!(is_digit || is_alpha)) begin
					// bad character or leading space aborts the message
					busy_q    <= 1'b1;
					kind_q    <= KIND_ERROR;
					started_q <= 1'b0;
				end else begin
					busy_q    <= 1'b1;
					kind_q    <= KIND_CHAR;
					started_q <= !char_data.last_of_message;
				end
			end else if (step) begin
				if (done_next) begin
					busy_q <= 1'b0;
				end
				if (kind_q == KIND_CHAR) begin
					priority if (gap_q) begin
						gap_q <= 1'b0;
					end else if (sym_gap_q) begin
						sym_gap_q <= 1'b0;
					end else begin
						sym_gap_q <= 1'b1;
						cnt_q     <= cnt_q - 3'd1;
					end
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!seg_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// code shifter and output register carry payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= entry[7:3];
		end else if (step && kind_q == KIND_CHAR && !gap_q && !sym_gap_q) begin
			code_q <= {1'b0, code_q[4:1]};
		end
		if (step) begin
			out_q <= seg_next;
		end
	end

	assign seg_valid = out_valid_q;
	assign seg_data  = out_q;

	`include "morse_code_keyer_assert.svh"

	`MCK_ASSERT_IMPLIES(a_char_has_symbols, clk, arst_n, busy_q && kind_q == KIND_CHAR, cnt_q != 3'd0)
	`MCK_ASSERT_IMPLIES(a_error_shape, clk, arst_n, seg_valid && seg_data.bad_char, seg_data.last && !seg_data.led_on && seg_data.units == UNITS_ERROR)
	`MCK_ASSERT_IMPLIES(a_symbol_length, clk, arst_n, seg_valid && seg_data.led_on, seg_data.units == UNITS_DOT || seg_data.units == UNITS_DASH)
	`MCK_ASSERT_NEXT(a_step_fills_output, clk, arst_n, step, seg_valid)

endmodule
